>>> hw/rtl/weighted_density_map_5x5_defines.svh
// Assertion helpers shared by the RTL files.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
// Define ASSERT_OFF to compile them away.
`ifndef WEIGHTED_DENSITY_MAP_5X5_DEFINES_SVH
`define WEIGHTED_DENSITY_MAP_5X5_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that a property holds at every sampled edge.
`define WDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that the consequent holds in the same cycle as the antecedent.
`define WDM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define WDM_ASSERT(lbl, prop, msg)
`define WDM_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/wdm_pkg.sv
`default_nettype none

package wdm_pkg;

  // Operation carried by an input transaction
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 8'd1;

  // Grid size registers
  localparam int SIZE_W = 9;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd3;

  // Window geometry and weights
  localparam int WIN_IDX_W = 3;
  localparam logic [WIN_IDX_W-1:0] WIN_LAST = 3'd4;
  localparam int WEIGHT_W = 4;
  localparam int ACC_W = 7;
  localparam logic [WEIGHT_W-1:0] WEIGHT_TAB [0:4][0:4] = '{
    '{4'd1, 4'd2, 4'd4, 4'd2, 4'd1},
    '{4'd2, 4'd6, 4'd8, 4'd6, 4'd2},
    '{4'd4, 4'd8, 4'd0, 4'd8, 4'd4},
    '{4'd2, 4'd6, 4'd8, 4'd6, 4'd2},
    '{4'd1, 4'd2, 4'd4, 4'd2, 4'd1}
  };

  // Result codes
  localparam int DENSITY_W = 8;
  localparam logic signed [DENSITY_W-1:0] DENSITY_NONE = -8'sd1;
  localparam logic signed [DENSITY_W-1:0] DENSITY_MAX  = 8'sd92;

  // Channel payloads
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] row;
    logic [7:0] col;
    logic       cell_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DENSITY_W-1:0] density;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [SIZE_W-1:0]    wdata;
  } cfg_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic mem_wr;
    logic mark_neg;
    logic scan_start;
    logic scan_step;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_read;
    logic skip;
    logic centre_occ;
    logic scan_last;
    logic out_free;
  } dp_status_t;

  // Window weight at offset (k, l); zero outside the window
  function automatic logic [WEIGHT_W-1:0] win_weight(input logic [WIN_IDX_W-1:0] k,
                                                     input logic [WIN_IDX_W-1:0] l);
    logic [WEIGHT_W-1:0] w;
    w = '0;
    if (k <= WIN_LAST && l <= WIN_LAST) begin
      w = WEIGHT_TAB[k][l];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/wdm_stream_if.sv
`default_nettype none

interface wdm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/wdm_ctrl.sv
`default_nettype none
`include "weighted_density_map_5x5_defines.svh"

module wdm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wdm_pkg::dp_status_t status,
  output wdm_pkg::dp_cmd_t    cmd
);
  import wdm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CENTRE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  // Decode commands and next state
  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.latch    = 1'b1;
          in_ready_nxt = 1'b0;
          state_nxt    = S_CENTRE;
        end
      end
      S_CENTRE: begin
        // a write completes here; a read fetches its centre cell
        if (!status.is_read) begin
          cmd.mem_wr   = 1'b1;
          in_ready_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.skip || status.centre_occ) begin
          cmd.mark_neg = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last window bit is accumulated in this cycle
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          in_ready_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  // Hold state and ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

  `WDM_ASSERT(a_cmd_exclusive, $onehot0({cmd.latch, cmd.mem_wr, cmd.mark_neg, cmd.scan_start, cmd.scan_step, cmd.load_out}), "wdm_ctrl: more than one datapath command in a cycle")

endmodule

`default_nettype wire

>>> hw/rtl/wdm_dpath.sv
`default_nettype none
`include "weighted_density_map_5x5_defines.svh"

module wdm_dpath #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wdm_pkg::in_item_t             in_data,
  input  logic                          cfg_wr,
  input  wdm_pkg::cfg_item_t            cfg_data,
  input  wdm_pkg::dp_cmd_t              cmd,
  output wdm_pkg::dp_status_t           status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [wdm_pkg::DENSITY_W-1:0] out_density
);
  import wdm_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;

  // Occupancy store
  logic mem [DEPTH];

  logic [SIZE_W-1:0] height_r, width_r;
  logic [SIZE_W-1:0] h_eff, w_eff;

  cmd_t       cmd_r;
  logic [7:0] row_r, col_r;
  logic       val_r;

  logic [WIN_IDX_W-1:0] k_r, l_r, kd_r, ld_r;
  logic                 acc_v_r;
  logic [ACC_W-1:0]     acc_r;
  logic                 neg_r;
  logic                 rd_bit_r;

  logic                        out_valid_r;
  logic signed [DENSITY_W-1:0] density_r;

  logic [SIZE_W-1:0] row_ext, col_ext;
  logic              in_grid;
  logic [SIZE_W-1:0] row_sum, col_sum, row_v, col_v, win_x, win_y;
  logic [AW-1:0]     centre_addr, scan_addr, rd_addr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= SIZE_RESET;
      width_r  <= SIZE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_data.reg_index)
        REG_GRID_HEIGHT: height_r <= cfg_data.wdata;
        REG_GRID_WIDTH:  width_r  <= cfg_data.wdata;
        default: ;
      endcase
    end
  end

  // Saturate sizes to 3..MAX
  always_comb begin
    if (height_r < SIZE_MIN) begin
      h_eff = SIZE_MIN;
    end else if (32'(height_r) > MAX_ROWS) begin
      h_eff = SIZE_W'(MAX_ROWS);
    end else begin
      h_eff = height_r;
    end
    if (width_r < SIZE_MIN) begin
      w_eff = SIZE_MIN;
    end else if (32'(width_r) > MAX_COLS) begin
      w_eff = SIZE_W'(MAX_COLS);
    end else begin
      w_eff = width_r;
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_data.cmd;
      row_r <= in_data.row;
      col_r <= in_data.col;
      val_r <= in_data.cell_value;
    end
  end

  // Position checks
  assign row_ext     = {1'b0, row_r};
  assign col_ext     = {1'b0, col_r};
  assign in_grid     = (row_ext < h_eff) && (col_ext < w_eff);
  assign centre_addr = {RW'(row_r), CW'(col_r)};

  // Wrapped window coordinates: centre + k - 2 lies in -1..size
  always_comb begin
    row_sum = row_ext + SIZE_W'(k_r);
    col_sum = col_ext + SIZE_W'(l_r);
    row_v   = row_sum - 9'd2;
    col_v   = col_sum - 9'd2;
    if (row_sum < 9'd2) begin
      win_x = h_eff - 9'd1;
    end else if (row_v >= h_eff) begin
      win_x = row_v - h_eff;
    end else begin
      win_x = row_v;
    end
    if (col_sum < 9'd2) begin
      win_y = w_eff - 9'd1;
    end else if (col_v >= w_eff) begin
      win_y = col_v - w_eff;
    end else begin
      win_y = col_v;
    end
  end

  assign scan_addr = {RW'(win_x), CW'(win_y)};
  assign rd_addr   = cmd.scan_step ? scan_addr : centre_addr;

  // Memory write port; drop writes outside the grid in use
  always_ff @(posedge clk) begin
    if (cmd.mem_wr && in_grid) begin
      mem[centre_addr] <= val_r;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    rd_bit_r <= mem[rd_addr];
  end

  // Window counters, row-major over the 5x5 offsets
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      k_r <= '0;
      l_r <= '0;
    end else if (cmd.scan_step) begin
      if (l_r == WIN_LAST) begin
        l_r <= '0;
        k_r <= k_r + 3'd1;
      end else begin
        l_r <= l_r + 3'd1;
      end
    end
  end

  // Track which offset the read data belongs to
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_v_r <= 1'b0;
    end else begin
      acc_v_r <= cmd.scan_step;
    end
    kd_r <= k_r;
    ld_r <= l_r;
  end

  // Accumulate weights of occupied neighbours
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      acc_r <= '0;
      neg_r <= 1'b0;
    end else begin
      if (acc_v_r && rd_bit_r) begin
        acc_r <= acc_r + ACC_W'(win_weight(kd_r, ld_r));
      end
      if (cmd.mark_neg) begin
        neg_r <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      density_r <= neg_r ? DENSITY_NONE : signed'({1'b0, acc_r});
    end
  end

  assign out_valid   = out_valid_r;
  assign out_density = density_r;

  // Status to the controller
  always_comb begin
    status.is_read    = (cmd_r == CMD_READ);
    status.skip       = !in_grid || (row_r == 8'd0) || (col_r == 8'd0) ||
                        (row_ext == h_eff - 9'd1) || (col_ext == w_eff - 9'd1);
    status.centre_occ = rd_bit_r;
    status.scan_last  = (k_r == WIN_LAST) && (l_r == WIN_LAST);
    status.out_free   = !out_valid_r || out_ready;
  end

  `WDM_ASSERT_IMP(a_load_when_free, cmd.load_out, (!out_valid_r || out_ready), "wdm_dpath: result overwritten before it was taken")
  `WDM_ASSERT_IMP(a_density_range, out_valid_r, ((density_r == DENSITY_NONE) || ((density_r >= 8'sd0) && (density_r <= DENSITY_MAX))), "wdm_dpath: density out of range")
  `WDM_ASSERT_IMP(a_scan_idle_when_emit, cmd.load_out, (!acc_v_r), "wdm_dpath: result loaded while a window read is pending")

endmodule

`default_nettype wire

>>> hw/rtl/weighted_density_map_5x5.sv
// Weighted 5x5 density map over a binary occupancy grid.
// in_if carries transactions {cmd, row, col, cell_value}; cmd CMD_WRITE stores
// cell_value at (row, col), CMD_READ returns one density on out_if: the weighted
// count of occupied cells in the 5x5 window around (row, col), wrapping at the
// grid edges, or -1 for border, occupied or out-of-range cells.
// cfg_if writes grid_height (index 0) and grid_width (index 1); it is always
// ready and must only be used while the block is idle.
// A write stores its cell before the next transaction is taken.
// A read that scans its window runs a centre fetch, 25 window reads
// through the single read port of the grid memory (one neighbour bit per cycle)
// and a drain, and then registers its result on out_if.
// A border, occupied or out-of-range read skips the window: its result is
// registered after the centre fetch and check, and only then is the next transaction taken.
// If out_if stalls, the next read is still accepted and computed, and waits in
// its final state until the held result has been taken.
// Reset clears the control state and sets both sizes to 256; the grid contents
// are undefined until written, and no clearing pass is run.
`default_nettype none

module weighted_density_map_5x5 #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  wdm_stream_if.sink   in_if,
  wdm_stream_if.source out_if,
  wdm_stream_if.sink   cfg_if
);
  import wdm_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       cfg_wr;

  // Configuration port never stalls
  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.valid && cfg_if.ready;

  wdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  wdm_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_if.data),
    .cfg_wr      (cfg_wr),
    .cfg_data    (cfg_if.data),
    .cmd         (dp_cmd),
    .status      (dp_status),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_density (out_if.data.density)
  );

endmodule

`default_nettype wire

>>> dv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wdm_pkg::*;

  localparam int GRID_DIM    = 256;
  localparam int SETTLE_CYC  = 40;
  localparam int RANDOM_OPS  = 1950;

  // Fixed 5x5 neighbour weights, centre excluded
  localparam int TAP_WEIGHT [0:4][0:4] = '{
    '{1, 2, 4, 2, 1},
    '{2, 6, 8, 6, 2},
    '{4, 8, 0, 8, 4},
    '{2, 6, 8, 6, 2},
    '{1, 2, 4, 2, 1}
  };

  logic clk;
  logic rst_n;

  wdm_stream_if #(.payload_t(in_item_t))  in_ch  ();
  wdm_stream_if #(.payload_t(out_item_t)) out_ch ();
  wdm_stream_if #(.payload_t(cfg_item_t)) cfg_ch ();

  weighted_density_map_5x5 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Mirror of the grid, its written flags and the size registers
  bit               occ_map    [GRID_DIM][GRID_DIM];
  bit               cell_known [GRID_DIM][GRID_DIM];
  logic [SIZE_W-1:0] rows_reg = SIZE_RESET;
  logic [SIZE_W-1:0] cols_reg = SIZE_RESET;

  logic signed [DENSITY_W-1:0] density_q [$];
  int errors        = 0;
  int applied_items = 0;
  bit in_calm       = 1'b0;
  bit out_calm      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run time
  initial begin
    #25_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic bit chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Effective sizes saturate to 3..256
  function automatic int eff_rows();
    if (rows_reg < SIZE_MIN) return int'(SIZE_MIN);
    if (rows_reg > GRID_DIM) return GRID_DIM;
    return int'(rows_reg);
  endfunction

  function automatic int eff_cols();
    if (cols_reg < SIZE_MIN) return int'(SIZE_MIN);
    if (cols_reg > GRID_DIM) return GRID_DIM;
    return int'(cols_reg);
  endfunction

  function automatic bit is_edge_or_outside(input int r, input int c);
    int h, w;
    h = eff_rows();
    w = eff_cols();
    return r >= h || c >= w || r == 0 || c == 0 || r == h - 1 || c == w - 1;
  endfunction

  // A read may only touch cells that have been written
  function automatic bit read_is_safe(input int r, input int c);
    int h, w;
    h = eff_rows();
    w = eff_cols();
    if (!cell_known[r][c]) return 1'b0;
    if (is_edge_or_outside(r, c)) return 1'b1;
    for (int k = 0; k < 5; k++) begin
      for (int l = 0; l < 5; l++) begin
        if (!cell_known[(r + k + h - 2) % h][(c + l + w - 2) % w]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Weighted count over the toroidal 5x5 window
  function automatic logic signed [DENSITY_W-1:0] predict_density(input int r, input int c);
    int h, w, acc;
    h = eff_rows();
    w = eff_cols();
    acc = 0;
    if (is_edge_or_outside(r, c) || occ_map[r][c]) return DENSITY_NONE;
    for (int k = 0; k < 5; k++) begin
      for (int l = 0; l < 5; l++) begin
        if (occ_map[(r + k + h - 2) % h][(c + l + w - 2) % w]) acc += TAP_WEIGHT[k][l];
      end
    end
    return acc[DENSITY_W-1:0];
  endfunction

  // Update the mirror for one accepted transaction
  function automatic void apply_cell_op(input in_item_t it);
    int r, c;
    r = int'(it.row);
    c = int'(it.col);
    if (it.cmd == CMD_WRITE) begin
      if (r < eff_rows() && c < eff_cols()) begin
        occ_map[r][c]    = it.cell_value;
        cell_known[r][c] = 1'b1;
        applied_items++;
      end
    end else begin
      density_q = {density_q, predict_density(r, c)};
      applied_items++;
    end
  endfunction

  // Send one transaction; valid is left high for a back-to-back follower
  task automatic send_cell_op(input in_item_t it);
    int gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_cell_op(it);
  endtask

  task automatic write_cell(input int r, input int c, input bit v);
    in_item_t it;
    it.cmd        = CMD_WRITE;
    it.row        = 8'(r);
    it.col        = 8'(c);
    it.cell_value = v;
    send_cell_op(it);
  endtask

  task automatic read_cell(input int r, input int c);
    in_item_t it;
    it.cmd        = CMD_READ;
    it.row        = 8'(r);
    it.col        = 8'(c);
    it.cell_value = 1'($urandom_range(1));
    if (read_is_safe(r, c)) send_cell_op(it);
  endtask

  // Drop valid, drain expected results, then let the block go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (density_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write both size registers back to back; the block must be idle
  task automatic write_sizes(input logic [SIZE_W-1:0] h, input logic [SIZE_W-1:0] w);
    cfg_item_t ci;
    for (int i = 0; i < 2; i++) begin
      ci.reg_index = (i == 0) ? REG_GRID_HEIGHT : REG_GRID_WIDTH;
      ci.wdata     = (i == 0) ? h : w;
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= ci;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      if (ci.reg_index == REG_GRID_HEIGHT) rows_reg = ci.wdata;
      else if (ci.reg_index == REG_GRID_WIDTH) cols_reg = ci.wdata;
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Border reads at the full reset size, corners included
  task automatic test_border_at_full_size();
    write_cell(255, 255, 1'b1);
    write_cell(0, 0, 1'b0);
    read_cell(0, 0);
    read_cell(255, 255);
  endtask

  // Smallest grid: empty window, full window, occupied centre, outside read
  task automatic test_min_grid_counts();
    settle();
    write_sizes(SIZE_MIN, SIZE_MIN);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) write_cell(r, c, 1'b0);
    end
    read_cell(1, 1);
    read_cell(0, 1);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r != 1 || c != 1) write_cell(r, c, 1'b1);
      end
    end
    read_cell(1, 1);
    write_cell(1, 1, 1'b1);
    read_cell(1, 1);
    read_cell(255, 255);
    write_cell(3, 1, 1'b1);
  endtask

  // Size registers below and above the legal range saturate
  task automatic test_size_saturation();
    settle();
    write_sizes(9'd0, 9'd2);
    write_cell(1, 1, 1'b0);
    read_cell(1, 1);
    settle();
    write_sizes(9'd511, 9'd257);
    read_cell(255, 255);
    read_cell(0, 0);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size(input int kind);
    unique case (kind)
      0: return SIZE_W'($urandom_range(16, 3));
      1: begin
        if (chance(50)) return SIZE_RESET;
        return chance(60) ? SIZE_W'($urandom_range(255, 17)) : SIZE_W'($urandom_range(16, 3));
      end
      default: return chance(50) ? SIZE_W'($urandom_range(2, 0))
                                 : SIZE_W'($urandom_range(511, 257));
    endcase
  endfunction

  // Small grid: fill it, then mix reads and writes across it
  task automatic grid_items(input int h, input int w);
    int occ, n, sel, r, c;
    bit found;
    occ = $urandom_range(100);
    for (int i = 0; i < h; i++) begin
      for (int j = 0; j < w; j++) write_cell(i, j, chance(occ));
    end
    n = $urandom_range(120, 40);
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        read_cell($urandom_range(h - 1), $urandom_range(w - 1));
      end else if (sel < 55) begin
        // look for a written cell outside the grid in use
        found = 1'b0;
        for (int t = 0; t < 8 && !found; t++) begin
          r = $urandom_range(255);
          c = $urandom_range(255);
          found = (r >= h || c >= w) && read_is_safe(r, c);
        end
        if (!found) begin
          r = $urandom_range(h - 1);
          c = $urandom_range(w - 1);
        end
        read_cell(r, c);
      end else if (sel < 95) begin
        write_cell($urandom_range(h - 1), $urandom_range(w - 1), chance(occ));
      end else begin
        write_cell($urandom_range(255), $urandom_range(255), 1'($urandom_range(1)));
      end
    end
  endtask

  // Large grid: write a window around a centre, then read near it or at another fully written cell
  task automatic patch_items(input int h, input int w);
    int rc, cc, occ, r, c;
    repeat ($urandom_range(6, 2)) begin
      rc  = $urandom_range(h - 1);
      cc  = $urandom_range(w - 1);
      occ = $urandom_range(100);
      for (int k = 0; k < 5; k++) begin
        for (int l = 0; l < 5; l++) begin
          write_cell((rc + k + h - 2) % h, (cc + l + w - 2) % w, chance(occ));
        end
      end
      write_cell(rc, cc, chance(30));
      repeat ($urandom_range(4, 1)) begin
        if (chance(50)) begin
          r = (rc + $urandom_range(4) + h - 2) % h;
          c = (cc + $urandom_range(4) + w - 2) % w;
        end else begin
          r = $urandom_range(255);
          c = $urandom_range(255);
        end
        if (!read_is_safe(r, c)) begin
          r = rc;
          c = cc;
        end
        read_cell(r, c);
      end
    end
  endtask

  // Random phases over a spread of grid sizes and idling patterns
  task automatic test_random_phases();
    int start, sel, kind, h, w;
    start = applied_items;
    while (applied_items - start < RANDOM_OPS) begin
      sel  = $urandom_range(99);
      kind = (sel < 65) ? 0 : (sel < 85) ? 1 : 2;
      settle();
      write_sizes(pick_size(kind), pick_size(kind));
      in_calm  = chance(20);
      out_calm = chance(20);
      h = eff_rows();
      w = eff_cols();
      if (h * w <= 400) grid_items(h, w);
      else patch_items(h, w);
    end
    in_calm  = 1'b0;
    out_calm = 1'b0;
  endtask

  // Compare each density transaction with the oldest prediction
  initial begin : density_checker
    int stall_left;
    logic signed [DENSITY_W-1:0] want;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (density_q.size() == 0) begin
          $display("%0t: unexpected density: expected none, got %0d",
                   $time, out_ch.data.density);
          errors++;
        end else begin
          want = density_q.pop_front();
          if (out_ch.data.density !== want) begin
            $display("%0t: density mismatch: expected %0d, got %0d",
                     $time, want, out_ch.data.density);
            errors++;
          end
        end
      end
      // hold ready low for a random stall now and then
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!out_calm && chance(30)) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    rst_n        <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_border_at_full_size();
    test_min_grid_counts();
    test_size_saturation();
    test_random_phases();

    settle();
    if (errors == 0 && density_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
